### hw/rtl/pucr_pkg.sv
// ----------------------------------------------------------------------------
// Peer upload credit engine package
// Field widths, register codes, reset values and arithmetic constants.
// ----------------------------------------------------------------------------
package pucr_pkg;

   localparam int MAX_PEERS_DEF = 64;

   localparam int CREDIT_W  = 48;
   localparam int ACTION_W  = 3;
   localparam int PEER_W    = 6;
   localparam int BYTES_W   = 24;
   localparam int RATE_W    = 32;
   localparam int GRANT_W   = 32;
   localparam int COUNT_W   = 7;

   localparam int INIT_W    = 24;
   localparam int REPAY_W   = 10;
   localparam int LARGE_W   = 7;
   localparam int SECS_W    = 8;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // bytes * repayment / 100 stays below 2^28
   localparam int GAIN_W    = 28;
   // rate * seconds * largesse fits in 47 bits
   localparam int TOTAL_W   = RATE_W + SECS_W + LARGE_W;
   localparam int MUL_W     = 32;

   // floor(x / 25) by reciprocal: (x * RECIP25) >> RECIP_SHIFT, one short at most
   localparam logic [MUL_W-1:0] RECIP25     = 32'hA3D7_0A3D;
   localparam int               RECIP_SHIFT = 36;
   localparam int               QUARTER_DIV = 25;
   localparam int               DIV_SCALE   = 100;
   localparam int               COUNT_SAT   = 127;

   localparam logic             RST_ENABLED = 1'b1;
   localparam logic [INIT_W-1:0]  RST_INIT  = 24'd65536;
   localparam logic [REPAY_W-1:0] RST_REPAY = 10'd133;
   localparam logic [LARGE_W-1:0] RST_LARGE = 7'd10;
   localparam logic [SECS_W-1:0]  RST_SECS  = 8'd5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_OPEN    = 3'd0,
      ACT_CONNECT = 3'd1,
      ACT_RECV    = 3'd2,
      ACT_SENT    = 3'd3,
      ACT_REFRESH = 3'd4,
      ACT_CLOSE   = 3'd5
   } act_type;

   typedef enum logic [2:0] {
      REG_ENABLED = 3'd0,
      REG_INIT    = 3'd1,
      REG_REPAY   = 3'd2,
      REG_LARGE   = 3'd3,
      REG_SECS    = 3'd4
   } reg_index_type;

   function automatic logic [CREDIT_W-1:0] sat_credit(input logic [CREDIT_W:0] v);
      logic [CREDIT_W-1:0] res;
      res = v[CREDIT_W-1:0];
      if (v[CREDIT_W] != v[CREDIT_W-1]) begin
         res = v[CREDIT_W] ? {1'b1, {(CREDIT_W-1){1'b0}}} : {1'b0, {(CREDIT_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

### hw/rtl/pucr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pucr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/peer_upload_credit_engine_unit.sv
// ----------------------------------------------------------------------------
// Peer upload credit engine
// Per-peer signed byte credit, connected marks and the upload gate.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low; its single result
// appears on the rsp_ ports for one cycle with rsp_valid and must be taken
// then, since the receiver cannot stall. Open, connect, sent, close and
// unused actions pass through the read and apply states; a received-bytes
// event adds the second multiply and fix states between them, as the credit
// memory read and one shared 32x32 multiplier, used twice for the repayment
// product and the divide by 100, run in sequence. A refresh while not seeding
// walks every peer through the credit memory read port, then, if any
// deadbeat is found, runs a bit-serial divider and a write walk over every
// peer before the apply state; with no deadbeat it goes straight to apply.
// A refresh while seeding passes through the read and apply states only.
// The credit of a peer that was never opened is undefined.
// ----------------------------------------------------------------------------
module peer_upload_credit_engine_unit #(
   parameter int MAX_PEERS = pucr_pkg::MAX_PEERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // event channel
   input  logic                              start,
   output logic                              busy,
   input  logic [pucr_pkg::ACTION_W-1:0]     req_action,
   input  logic [pucr_pkg::PEER_W-1:0]       req_peer_index,
   input  logic [pucr_pkg::BYTES_W-1:0]      req_byte_count,
   input  logic                              req_seeding,
   input  logic [pucr_pkg::RATE_W-1:0]       req_download_rate,
   // result channel
   output logic                              rsp_valid,
   output logic signed [pucr_pkg::CREDIT_W-1:0] rsp_peer_credit,
   output logic                              rsp_upload_allowed,
   output logic [pucr_pkg::COUNT_W-1:0]      rsp_deadbeat_count,
   output logic [pucr_pkg::GRANT_W-1:0]      rsp_grant_per_peer,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pucr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pucr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pucr_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   import pucr_pkg::*;

   localparam int IDX_W = $clog2(MAX_PEERS);
   localparam int CNT_W = $clog2(MAX_PEERS + 1);
   localparam int DVS_W = CNT_W + 7;
   localparam int STEP_W = $clog2(TOTAL_W);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PEERS - 1);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_READ  = 9'b000000010,
      ST_MUL2  = 9'b000000100,
      ST_FIX   = 9'b000001000,
      ST_RMUL  = 9'b000010000,
      ST_SCAN  = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_GRANT = 9'b010000000,
      ST_APPLY = 9'b100000000
   } state_type;

   state_type state_ff;

   // configuration registers
   logic                 enabled_ff;
   logic [INIT_W-1:0]    init_ff;
   logic [REPAY_W-1:0]   repay_ff;
   logic [LARGE_W-1:0]   large_ff;
   logic [SECS_W-1:0]    secs_ff;

   // latched event
   act_type              act_ff;
   logic [PEER_W-1:0]    idx_ff;
   logic [BYTES_W-1:0]   bytes_ff;
   logic                 seed_ff;
   logic [RATE_W-1:0]    rate_ff;

   // working registers
   logic [CREDIT_W-1:0]  credit_ff;
   logic [2*MUL_W-1:0]   prod_ff;
   logic [MUL_W-1:0]     quarter_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic [IDX_W-1:0]     scan_ff;
   logic                 issue_ff;
   logic                 chk_vld_ff;
   logic [IDX_W-1:0]     chk_idx_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [MAX_PEERS-1:0] dead_ff;
   logic [MAX_PEERS-1:0] conn_ff;
   logic [DVS_W-1:0]     dvs_ff;
   logic [DVS_W-1:0]     rem_ff;
   logic [TOTAL_W-1:0]   quo_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [GRANT_W-1:0]   grant_ff;

   // result registers
   logic                 rsp_valid_ff;
   logic [CREDIT_W-1:0]  rsp_credit_ff;
   logic                 rsp_allowed_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic [GRANT_W-1:0]   rsp_grant_ff;

   // shared multiplier
   logic [MUL_W-1:0]     mul_a;
   logic [MUL_W-1:0]     mul_b;
   logic [2*MUL_W-1:0]   mul_p;

   // memory port
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [CREDIT_W-1:0]  ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [CREDIT_W-1:0]  ram_rdata;

   logic                 accept;
   logic                 csr_wr;
   logic [2:0]           csr_idx;
   logic [IDX_W-1:0]     peer_addr;
   logic                 idx_ok;

   logic [GAIN_W-1:0]    q0;
   logic [MUL_W:0]       q0_x25;
   logic [MUL_W:0]       q0_rem;
   logic                 scan_dead;
   logic [CNT_W-1:0]     count_in;
   logic [DVS_W:0]       trial;
   logic                 trial_ge;
   logic [DVS_W-1:0]     rem_in;
   logic [TOTAL_W-1:0]   quo_in;
   logic [GRANT_W-1:0]   grant_in;
   logic [CREDIT_W:0]    sum_rx;
   logic [CREDIT_W:0]    dif_tx;
   logic [CREDIT_W-1:0]  credit_in;
   logic                 apply_wr;
   logic [CREDIT_W-1:0]  out_credit;
   logic [COUNT_W-1:0]   out_count;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_wr    = psel && penable && pwrite && pready;
   assign csr_idx   = paddr[4:2];
   assign pready    = 1'b1;
   assign peer_addr = IDX_W'(idx_ff);
   assign idx_ok    = (32'(idx_ff) < 32'(MAX_PEERS));

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= RST_ENABLED;
         init_ff    <= RST_INIT;
         repay_ff   <= RST_REPAY;
         large_ff   <= RST_LARGE;
         secs_ff    <= RST_SECS;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ENABLED: enabled_ff <= pwdata[0];
            REG_INIT:    init_ff    <= pwdata[INIT_W-1:0];
            REG_REPAY:   repay_ff   <= pwdata[REPAY_W-1:0];
            REG_LARGE:   large_ff   <= pwdata[LARGE_W-1:0];
            REG_SECS:    secs_ff    <= pwdata[SECS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ENABLED: prdata = CSR_DATA_W'(enabled_ff);
         REG_INIT:    prdata = CSR_DATA_W'(init_ff);
         REG_REPAY:   prdata = CSR_DATA_W'(repay_ff);
         REG_LARGE:   prdata = CSR_DATA_W'(large_ff);
         REG_SECS:    prdata = CSR_DATA_W'(secs_ff);
         default:     prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // shared multiplier
   // ------------------------------------------------------------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_READ: begin
            if (act_ff == ACT_REFRESH) begin
               mul_a = MUL_W'(secs_ff);
               mul_b = MUL_W'(large_ff);
            end else begin
               mul_a = MUL_W'(bytes_ff);
               mul_b = MUL_W'(repay_ff);
            end
         end
         ST_MUL2: begin
            // x/100 = (x/4)/25
            mul_a = prod_ff[MUL_W+1:2];
            mul_b = RECIP25;
         end
         ST_RMUL: begin
            mul_a = rate_ff;
            mul_b = MUL_W'(prod_ff[SECS_W+LARGE_W-1:0]);
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // reciprocal correction
   assign q0     = prod_ff[RECIP_SHIFT+GAIN_W-1:RECIP_SHIFT];
   assign q0_x25 = (MUL_W+1)'(q0) * (MUL_W+1)'(QUARTER_DIV);
   assign q0_rem = (MUL_W+1)'(quarter_ff) - q0_x25;

   // ------------------------------------------------------------------
   // deadbeat scan and divider
   // ------------------------------------------------------------------
   assign scan_dead = chk_vld_ff && conn_ff[chk_idx_ff] && ram_rdata[CREDIT_W-1];
   assign count_in  = count_ff + CNT_W'(scan_dead);

   assign trial    = {rem_ff, quo_ff[TOTAL_W-1]};
   assign trial_ge = (trial >= {1'b0, dvs_ff});
   assign rem_in   = trial_ge ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
   assign quo_in   = {quo_ff[TOTAL_W-2:0], trial_ge};
   assign grant_in = (|quo_in[TOTAL_W-1:GRANT_W]) ? {GRANT_W{1'b1}} : quo_in[GRANT_W-1:0];

   // ------------------------------------------------------------------
   // credit update
   // ------------------------------------------------------------------
   assign sum_rx = {credit_ff[CREDIT_W-1], credit_ff} + (CREDIT_W+1)'(gain_ff);
   assign dif_tx = {credit_ff[CREDIT_W-1], credit_ff} - (CREDIT_W+1)'(bytes_ff);

   always_comb begin
      credit_in = credit_ff;
      apply_wr  = 1'b0;
      case (act_ff)
         ACT_OPEN: begin
            credit_in = CREDIT_W'(init_ff);
            apply_wr  = idx_ok;
         end
         ACT_RECV: begin
            credit_in = sat_credit(sum_rx);
            apply_wr  = idx_ok;
         end
         ACT_SENT: begin
            credit_in = sat_credit(dif_tx);
            apply_wr  = idx_ok;
         end
         default: ;
      endcase
   end

   assign out_credit = ((act_ff == ACT_REFRESH) || !idx_ok) ? '0 : credit_in;
   assign out_count  = (32'(count_ff) > 32'(COUNT_SAT)) ? COUNT_W'(COUNT_SAT)
                                                        : COUNT_W'(count_ff);

   // ------------------------------------------------------------------
   // credit memory
   // ------------------------------------------------------------------
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = peer_addr;
      ram_wdata = credit_in;
      if (state_ff == ST_APPLY) begin
         ram_we = apply_wr;
      end else if (state_ff == ST_GRANT) begin
         ram_we    = dead_ff[scan_ff];
         ram_waddr = scan_ff;
         ram_wdata = CREDIT_W'(grant_ff);
      end
   end

   always_comb begin
      if (state_ff == ST_IDLE) begin
         ram_raddr = IDX_W'(req_peer_index);
      end else if (state_ff == ST_SCAN) begin
         ram_raddr = scan_ff;
      end else begin
         ram_raddr = peer_addr;
      end
   end

   pucr_ram #(
      .WIDTH (CREDIT_W),
      .DEPTH (MAX_PEERS)
   ) u_credit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         conn_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_APPLY);
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  act_ff   <= act_type'(req_action);
                  idx_ff   <= req_peer_index;
                  bytes_ff <= req_byte_count;
                  seed_ff  <= req_seeding;
                  rate_ff  <= req_download_rate;
                  count_ff <= '0;
                  grant_ff <= '0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               credit_ff <= ram_rdata;
               prod_ff   <= mul_p;
               if (act_ff == ACT_RECV) begin
                  state_ff <= ST_MUL2;
               end else if (act_ff == ACT_REFRESH && !seed_ff) begin
                  state_ff <= ST_RMUL;
               end else begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_MUL2: begin
               quarter_ff <= prod_ff[MUL_W+1:2];
               prod_ff    <= mul_p;
               state_ff   <= ST_FIX;
            end
            ST_FIX: begin
               gain_ff  <= q0 + GAIN_W'(q0_rem >= (MUL_W+1)'(QUARTER_DIV));
               state_ff <= ST_APPLY;
            end
            ST_RMUL: begin
               prod_ff    <= mul_p;
               scan_ff    <= '0;
               issue_ff   <= 1'b1;
               chk_vld_ff <= 1'b0;
               state_ff   <= ST_SCAN;
            end
            ST_SCAN: begin
               // read one entry a cycle, check it the cycle after
               chk_vld_ff <= issue_ff;
               chk_idx_ff <= scan_ff;
               if (issue_ff) begin
                  if (scan_ff == LAST_IDX) begin
                     issue_ff <= 1'b0;
                  end else begin
                     scan_ff <= scan_ff + 1'b1;
                  end
               end
               if (chk_vld_ff) begin
                  dead_ff[chk_idx_ff] <= scan_dead;
               end
               count_ff <= count_in;
               if (chk_vld_ff && chk_idx_ff == LAST_IDX) begin
                  dvs_ff     <= DVS_W'(count_in) * DVS_W'(DIV_SCALE);
                  rem_ff     <= '0;
                  quo_ff     <= prod_ff[TOTAL_W-1:0];
                  step_ff    <= '0;
                  state_ff   <= (count_in == '0) ? ST_APPLY : ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff  <= rem_in;
               quo_ff  <= quo_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(TOTAL_W - 1)) begin
                  grant_ff <= grant_in;
                  scan_ff  <= '0;
                  state_ff <= ST_GRANT;
               end
            end
            ST_GRANT: begin
               if (scan_ff == LAST_IDX) begin
                  state_ff <= ST_APPLY;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            ST_APPLY: begin
               if (idx_ok) begin
                  case (act_ff)
                     ACT_OPEN, ACT_CLOSE: conn_ff[peer_addr] <= 1'b0;
                     ACT_CONNECT:         conn_ff[peer_addr] <= 1'b1;
                     default: ;
                  endcase
               end
               rsp_credit_ff  <= out_credit;
               rsp_allowed_ff <= !(enabled_ff && !seed_ff && out_credit[CREDIT_W-1]);
               if (act_ff == ACT_REFRESH && !seed_ff) begin
                  rsp_count_ff <= out_count;
                  rsp_grant_ff <= grant_ff;
               end else begin
                  rsp_count_ff <= '0;
                  rsp_grant_ff <= '0;
               end
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_peer_credit    = rsp_credit_ff;
   assign rsp_upload_allowed = rsp_allowed_ff;
   assign rsp_deadbeat_count = rsp_count_ff;
   assign rsp_grant_per_peer = rsp_grant_ff;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Peer upload credit engine testbench
// A short list of directed events, some with their results typed in, is
// followed by random event bursts under several register settings. Every
// result beat is checked, field by field and in order, against its typed
// result or a predictor of the peer credit table; APB writes are read back.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pucr_pkg::*;

   localparam int PEERS           = MAX_PEERS_DEF;
   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 270;
   // worst case: every item a full refresh walk plus the longest sender gap
   localparam int LIMIT_CYCLES    = 2000000;

   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

   localparam longint CREDIT_HI = 64'sd140737488355327;
   localparam longint CREDIT_LO = -CREDIT_HI - 64'sd1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [PEER_W-1:0]   peer;
      logic [BYTES_W-1:0]  bytes;
      logic                seeding;
      logic [RATE_W-1:0]   rate;
   } credit_event_type;

   typedef struct packed {
      logic [CREDIT_W-1:0] credit;
      logic                allowed;
      logic [COUNT_W-1:0]  deadbeats;
      logic [GRANT_W-1:0]  grant;
   } credit_reply_type;

   typedef struct packed {
      credit_event_type ev;
      logic             typed;
      credit_reply_type reply;
   } scenario_row_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [ACTION_W-1:0] req_action;
   logic [PEER_W-1:0]   req_peer_index;
   logic [BYTES_W-1:0]  req_byte_count;
   logic                req_seeding;
   logic [RATE_W-1:0]   req_download_rate;
   logic                rsp_valid;
   logic signed [CREDIT_W-1:0] rsp_peer_credit;
   logic                rsp_upload_allowed;
   logic [COUNT_W-1:0]  rsp_deadbeat_count;
   logic [GRANT_W-1:0]  rsp_grant_per_peer;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // predictor state
   longint credit_tbl [PEERS];
   bit     linked     [PEERS];
   bit     opened     [PEERS];
   bit                 cfg_enabled;
   logic [INIT_W-1:0]  cfg_init;
   logic [REPAY_W-1:0] cfg_repay;
   logic [LARGE_W-1:0] cfg_large;
   logic [SECS_W-1:0]  cfg_secs;

   credit_reply_type due_credit_beats [$];
   scenario_row_type scenario_rows [$];
   int fail_count;

   peer_upload_credit_engine_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_peer_index     (req_peer_index),
      .req_byte_count     (req_byte_count),
      .req_seeding        (req_seeding),
      .req_download_rate  (req_download_rate),
      .rsp_valid          (rsp_valid),
      .rsp_peer_credit    (rsp_peer_credit),
      .rsp_upload_allowed (rsp_upload_allowed),
      .rsp_deadbeat_count (rsp_deadbeat_count),
      .rsp_grant_per_peer (rsp_grant_per_peer),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("tb: done, errors");
      $finish;
   end

   function automatic longint clamp_credit(input longint v);
      if (v > CREDIT_HI) return CREDIT_HI;
      if (v < CREDIT_LO) return CREDIT_LO;
      return v;
   endfunction

   // Advance the credit table by one event and return the beat it yields.
   function automatic credit_reply_type predict_credit_event(input credit_event_type ev);
      credit_reply_type r;
      longint cr;
      longint unsigned n;
      longint unsigned total;
      longint unsigned share;
      longint unsigned gain;
      int p;
      int i;
      r = '0;
      cr = 0;
      p = ev.peer;
      if (ev.action == ACT_REFRESH) begin
         if (!ev.seeding) begin
            n = 0;
            for (i = 0; i < PEERS; i++)
               if (linked[i] && credit_tbl[i] < 0) n++;
            if (n != 0) begin
               total = ev.rate;
               total = total * cfg_secs;
               total = total * cfg_large;
               share = total / (DIV_SCALE * n);
               if (share > 64'hFFFF_FFFF) share = 64'hFFFF_FFFF;
               for (i = 0; i < PEERS; i++)
                  if (linked[i] && credit_tbl[i] < 0) credit_tbl[i] = longint'(share);
               r.grant = share[GRANT_W-1:0];
            end
            r.deadbeats = (n > COUNT_SAT) ? COUNT_W'(COUNT_SAT) : COUNT_W'(n);
         end
      end else begin
         case (ev.action)
            ACT_OPEN: begin
               credit_tbl[p] = longint'(cfg_init);
               linked[p] = 1'b0;
               opened[p] = 1'b1;
            end
            ACT_CONNECT: linked[p] = 1'b1;
            ACT_RECV: begin
               gain = ev.bytes;
               gain = gain * cfg_repay / DIV_SCALE;
               credit_tbl[p] = clamp_credit(credit_tbl[p] + longint'(gain));
            end
            ACT_SENT: credit_tbl[p] = clamp_credit(credit_tbl[p] - longint'(ev.bytes));
            ACT_CLOSE: linked[p] = 1'b0;
            default: ;
         endcase
         cr = credit_tbl[p];
      end
      r.credit = cr[CREDIT_W-1:0];
      r.allowed = !(cfg_enabled && !ev.seeding && cr < 0);
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_value(input reg_index_type idx);
      case (idx)
         REG_ENABLED: return CSR_DATA_W'(cfg_enabled);
         REG_INIT:    return CSR_DATA_W'(cfg_init);
         REG_REPAY:   return CSR_DATA_W'(cfg_repay);
         REG_LARGE:   return CSR_DATA_W'(cfg_large);
         default:     return CSR_DATA_W'(cfg_secs);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_mask(input reg_index_type idx);
      case (idx)
         REG_ENABLED: return 32'h1;
         REG_INIT:    return 32'hFF_FFFF;
         REG_REPAY:   return 32'h3FF;
         REG_LARGE:   return 32'h7F;
         default:     return 32'hFF;
      endcase
   endfunction

   task automatic check_reg(input reg_index_type idx);
      logic [CSR_DATA_W-1:0] want;
      want = reg_value(idx);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         fail_count++;
         $display("%0t: register %s readback expected %0h got %0h",
                  $time, idx.name(), want, prdata);
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      // bits above the register width drop
      case (idx)
         REG_ENABLED: cfg_enabled = value[0];
         REG_INIT:    cfg_init = value[INIT_W-1:0];
         REG_REPAY:   cfg_repay = value[REPAY_W-1:0];
         REG_LARGE:   cfg_large = value[LARGE_W-1:0];
         default:     cfg_secs = value[SECS_W-1:0];
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      check_reg(idx);
   endtask

   task automatic send_event(input credit_event_type ev, input logic typed,
                             input credit_reply_type typed_reply);
      credit_reply_type pred;
      @(negedge clock);
      start = 1'b1;
      req_action = ev.action;
      req_peer_index = ev.peer;
      req_byte_count = ev.bytes;
      req_seeding = ev.seeding;
      req_download_rate = ev.rate;
      do @(posedge clock); while (busy);
      pred = predict_credit_event(ev);
      due_credit_beats.push_back(typed ? typed_reply : pred);
   endtask

   // Drop start and hold until every result beat is in and the block is idle.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (due_credit_beats.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic add_row(input logic [ACTION_W-1:0] action, input int peer,
                          input logic [BYTES_W-1:0] bytes, input logic seeding,
                          input logic [RATE_W-1:0] rate, input logic typed,
                          input longint credit, input logic allowed,
                          input int deadbeats, input logic [GRANT_W-1:0] grant);
      scenario_row_type row;
      row.ev.action = action;
      row.ev.peer = PEER_W'(peer);
      row.ev.bytes = bytes;
      row.ev.seeding = seeding;
      row.ev.rate = rate;
      row.typed = typed;
      row.reply.credit = credit[CREDIT_W-1:0];
      row.reply.allowed = allowed;
      row.reply.deadbeats = COUNT_W'(deadbeats);
      row.reply.grant = grant;
      scenario_rows.push_back(row);
   endtask

   always @(posedge clock) begin : check_beat
      credit_reply_type want;
      if (!reset && rsp_valid) begin
         if (due_credit_beats.size() == 0) begin
            fail_count++;
            $display("%0t: result beat with none expected, credit %0d",
                     $time, rsp_peer_credit);
         end else begin
            want = due_credit_beats.pop_front();
            if (rsp_peer_credit !== want.credit) begin
               fail_count++;
               $display("%0t: peer_credit expected %0d got %0d",
                        $time, $signed(want.credit), rsp_peer_credit);
            end
            if (rsp_upload_allowed !== want.allowed) begin
               fail_count++;
               $display("%0t: upload_allowed expected %0b got %0b",
                        $time, want.allowed, rsp_upload_allowed);
            end
            if (rsp_deadbeat_count !== want.deadbeats) begin
               fail_count++;
               $display("%0t: deadbeat_count expected %0d got %0d",
                        $time, want.deadbeats, rsp_deadbeat_count);
            end
            if (rsp_grant_per_peer !== want.grant) begin
               fail_count++;
               $display("%0t: grant_per_peer expected %0d got %0d",
                        $time, want.grant, rsp_grant_per_peer);
            end
         end
      end
   end

   initial begin : stimulus
      credit_event_type ev;
      credit_reply_type no_reply;
      logic [CSR_DATA_W-1:0] setting [5];
      logic [CSR_DATA_W-1:0] noise;
      int phase;
      int k;
      int sel;
      int burst_left;

      fail_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_OPEN;
      req_peer_index = '0;
      req_byte_count = '0;
      req_seeding = 1'b0;
      req_download_rate = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      no_reply = '0;
      for (k = 0; k < PEERS; k++) begin
         credit_tbl[k] = 0;
         linked[k] = 1'b0;
         opened[k] = 1'b0;
      end
      cfg_enabled = RST_ENABLED;
      cfg_init = RST_INIT;
      cfg_repay = RST_REPAY;
      cfg_large = RST_LARGE;
      cfg_secs = RST_SECS;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < 5; k++) check_reg(reg_index_type'(k));

      // directed events under reset settings
      add_row(ACT_OPEN, 0, 24'd0, 1'b0, 32'd0, 1'b1, 65536, 1'b1, 0, 0);
      add_row(ACT_OPEN, 63, 24'hFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 65536, 1'b1, 0, 0);
      add_row(ACT_CONNECT, 0, 24'd0, 1'b0, 32'd0, 1'b1, 65536, 1'b1, 0, 0);
      add_row(ACT_RECV, 0, 24'hFF_FFFF, 1'b0, 32'd0, 1'b0, 0, 1'b0, 0, 0);
      add_row(ACT_RECV, 63, 24'd0, 1'b0, 32'd0, 1'b1, 65536, 1'b1, 0, 0);
      add_row(ACT_SENT, 63, 24'hFF_FFFF, 1'b0, 32'd0, 1'b1, -16711679, 1'b0, 0, 0);
      add_row(ACT_SENT, 63, 24'd0, 1'b1, 32'd0, 1'b1, -16711679, 1'b1, 0, 0);
      add_row(ACT_REFRESH, 5, 24'd0, 1'b1, 32'hFFFF_FFFF, 1'b1, 0, 1'b1, 0, 0);
      add_row(ACT_REFRESH, 0, 24'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, 0, 1'b1, 0, 0);
      add_row(ACT_CONNECT, 63, 24'd0, 1'b0, 32'd0, 1'b1, -16711679, 1'b0, 0, 0);
      add_row(ACT_REFRESH, 0, 24'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, 0, 1'b0, 0, 0);
      add_row(ACT_SPARE_LO, 63, 24'd0, 1'b0, 32'd0, 1'b0, 0, 1'b0, 0, 0);
      add_row(ACT_SENT, 0, 24'hFF_FFFF, 1'b0, 32'd0, 1'b0, 0, 1'b0, 0, 0);
      add_row(ACT_SENT, 0, 24'hFF_FFFF, 1'b0, 32'd0, 1'b0, 0, 1'b0, 0, 0);
      add_row(ACT_OPEN, 1, 24'd0, 1'b0, 32'd0, 1'b1, 65536, 1'b1, 0, 0);
      add_row(ACT_CONNECT, 1, 24'd0, 1'b0, 32'd0, 1'b1, 65536, 1'b1, 0, 0);
      add_row(ACT_SENT, 1, 24'hFF_FFFF, 1'b0, 32'd0, 1'b1, -16711679, 1'b0, 0, 0);
      // two deadbeats, zero rate: both land on zero credit
      add_row(ACT_REFRESH, 0, 24'd0, 1'b0, 32'd0, 1'b1, 0, 1'b1, 2, 0);
      add_row(ACT_SPARE_HI, 1, 24'd0, 1'b0, 32'd0, 1'b1, 0, 1'b1, 0, 0);
      add_row(ACT_CLOSE, 1, 24'd0, 1'b0, 32'd0, 1'b1, 0, 1'b1, 0, 0);
      add_row(ACT_SENT, 1, 24'd1, 1'b0, 32'd0, 1'b1, -1, 1'b0, 0, 0);
      // closed peer is no deadbeat
      add_row(ACT_REFRESH, 0, 24'd0, 1'b0, 32'd12345, 1'b1, 0, 1'b1, 0, 0);
      add_row(ACT_CLOSE, 0, 24'd0, 1'b0, 32'd0, 1'b0, 0, 1'b0, 0, 0);

      foreach (scenario_rows[k])
         send_event(scenario_rows[k].ev, scenario_rows[k].typed, scenario_rows[k].reply);

      for (phase = 1; phase <= PHASES; phase++) begin
         settle();
         case (phase)
            1: setting = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd1};
            2: setting = '{32'd1, 32'hFF_FFFF, 32'd1023, 32'd100, 32'd255};
            default: begin
               setting[0] = $urandom_range(0, 1);
               setting[1] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, 24'hFF_FFFF);
               setting[2] = $urandom_range(0, 1023);
               setting[3] = $urandom_range(0, 100);
               setting[4] = $urandom_range(1, 255);
            end
         endcase
         for (k = 0; k < 5; k++) begin
            noise = ($urandom_range(0, 1) == 0) ? 32'd0
                                                : ($urandom & ~reg_mask(reg_index_type'(k)));
            write_reg(reg_index_type'(k), setting[k] | noise);
         end

         burst_left = $urandom_range(1, 60);
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (burst_left == 0) begin
               @(negedge clock);
               start = 1'b0;
               repeat ($urandom_range(0, 8)) @(negedge clock);
               burst_left = $urandom_range(1, 60);
            end
            burst_left--;

            sel = $urandom_range(0, 99);
            if (sel < 10)      ev.action = ACT_OPEN;
            else if (sel < 25) ev.action = ACT_CONNECT;
            else if (sel < 50) ev.action = ACT_RECV;
            else if (sel < 80) ev.action = ACT_SENT;
            else if (sel < 88) ev.action = ACT_REFRESH;
            else if (sel < 95) ev.action = ACT_CLOSE;
            else               ev.action = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
            // a few hot peers make deadbeats likely
            ev.peer = PEER_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, PEERS - 1)
                                                          : $urandom_range(0, 7));
            // never touch a credit entry that was not opened
            if (!opened[ev.peer] && ev.action != ACT_REFRESH) ev.action = ACT_OPEN;
            ev.bytes = BYTES_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095)
                                                            : $urandom);
            ev.seeding = ($urandom_range(0, 3) == 0);
            ev.rate = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000) : $urandom;
            send_event(ev, 1'b0, no_reply);
         end
      end

      @(negedge clock);
      start = 1'b0;
      while (due_credit_beats.size() != 0) @(posedge clock);
      repeat (2 * PEERS + 60) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
